// File: sv/grcd_pkg.sv
// ----------------------------------------------------------------------------
// grcd_pkg: shared types, constants and helper functions of the grid ray caster
// Holds the job format between the front and the walk, the reciprocal unit's
// request and response, the arctangent table and the fixed-point helpers.
// ----------------------------------------------------------------------------
package grcd_pkg;

    // Default parameter values of the top level.
    localparam int DEF_GRID_WIDTH  = 32;
    localparam int DEF_GRID_HEIGHT = 32;
    localparam int DEF_FRAC_BITS   = 11;
    localparam int DEF_ANGLE_BITS  = 12;

    // Fixed field widths.
    localparam int DIST_W     = 17;
    localparam int POS_W      = 16;
    localparam int MAG_W      = 16;
    localparam int ANGLE_W    = 12;
    localparam int HFRAC_W    = 11;
    localparam int CELL_IDX_W = 5;

    localparam logic [DIST_W-1:0]   DIST_MAX    = 17'h1FFFF;
    localparam logic [MAG_W-1:0]    Q15_ONE     = 16'h8000;
    localparam logic signed [17:0]  CORDIC_GAIN = 18'sd19899;
    localparam int                  CORDIC_STAGES = 14;

    // Operation codes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Depth of the job queue between front and walk (a power of two).
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
    } grcd_recip_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] step_x;
        logic [DIST_W-1:0] step_y;
    } grcd_recip_rsp_t;

    typedef struct packed {
        logic                  is_cast;
        logic [CELL_IDX_W-1:0] row;
        logic [CELL_IDX_W-1:0] col;
        logic                  wall;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic [MAG_W-1:0]      mag_x;
        logic [MAG_W-1:0]      mag_y;
        logic                  neg_x;
        logic                  neg_y;
        logic [DIST_W-1:0]     step_x;
        logic [DIST_W-1:0]     step_y;
        logic [DIST_W-1:0]     len_x;
        logic [DIST_W-1:0]     len_y;
    } grcd_job_t;

    // Arctangent of 2^-i in units of 2^16 codes per turn.
    function automatic logic [13:0] grcd_atan(input logic [3:0] idx);
        logic [13:0] v;
        begin
            case (idx)
                4'd0:    v = 14'd8192;
                4'd1:    v = 14'd4836;
                4'd2:    v = 14'd2555;
                4'd3:    v = 14'd1297;
                4'd4:    v = 14'd651;
                4'd5:    v = 14'd326;
                4'd6:    v = 14'd163;
                4'd7:    v = 14'd81;
                4'd8:    v = 14'd41;
                4'd9:    v = 14'd20;
                4'd10:   v = 14'd10;
                4'd11:   v = 14'd5;
                4'd12:   v = 14'd3;
                4'd13:   v = 14'd1;
                default: v = 14'd0;
            endcase
            return v;
        end
    endfunction

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [17:0] grcd_shr_tz(input logic signed [17:0] v,
                                                      input logic [3:0] sh);
        logic [17:0] mag;
        begin
            mag = v[17] ? 18'(-v) : 18'(v);
            mag = mag >> sh;
            return v[17] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    // Clamp a rotator output to a Q1.15 magnitude of 0 to one.
    function automatic logic [MAG_W-1:0] grcd_clamp_q15(input logic signed [17:0] v);
        logic [MAG_W-1:0] r;
        begin
            if (v[17])
                r = '0;
            else if (v > 18'sd32768)
                r = Q15_ONE;
            else
                r = v[MAG_W-1:0];
            return r;
        end
    endfunction

    // Saturate an 18-bit distance to the 17-bit range.
    function automatic logic [DIST_W-1:0] grcd_sat_dist(input logic [DIST_W:0] v);
        return v[DIST_W] ? DIST_MAX : v[DIST_W-1:0];
    endfunction

endpackage

// File: sv/grcd_ifs.sv
// ----------------------------------------------------------------------------
// grcd channel interfaces: input item channel and result channel
// Each channel carries valid, ready and the item fields.
// ----------------------------------------------------------------------------
interface grcd_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [4:0]  cell_row;
    logic [4:0]  cell_col;
    logic        wall_bit;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] angle;

    modport source (output valid, op, cell_row, cell_col, wall_bit, pos_x, pos_y, angle,
                    input ready);
    modport sink   (input valid, op, cell_row, cell_col, wall_bit, pos_x, pos_y, angle,
                    output ready);
endinterface

interface grcd_result_if;
    logic        valid;
    logic        ready;
    logic        hit_found;
    logic        vertical_side;
    logic [16:0] hit_distance;
    logic [10:0] hit_fraction;

    modport source (output valid, hit_found, vertical_side, hit_distance, hit_fraction,
                    input ready);
    modport sink   (input valid, hit_found, vertical_side, hit_distance, hit_fraction,
                    output ready);
endinterface

// File: sv/grcd_recip.sv
// ----------------------------------------------------------------------------
// grcd_recip: two-lane iterative reciprocal for the unit steps
// Computes floor(2^(15+FRAC_BITS) / mag) for both axes, one quotient bit per
// cycle, saturating to the distance maximum for small or zero magnitudes.
// ----------------------------------------------------------------------------
module grcd_recip
    import grcd_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  grcd_recip_req_t req,
    output grcd_recip_rsp_t rsp
);

    // Partial remainder once the quotient bits above the distance width are gone.
    localparam logic [DIST_W-1:0] R_INIT  = DIST_W'(1 << (FRAC_BITS - 2));
    localparam logic [MAG_W-1:0]  SAT_LIM = MAG_W'(1 << (FRAC_BITS - 2));
    localparam int                CNT_W   = $clog2(DIST_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIST_W-1:0] rem_x_reg, rem_y_reg;
    logic [DIST_W-1:0] quo_x_reg, quo_y_reg;
    logic [MAG_W-1:0]  div_x_reg, div_y_reg;
    logic              sat_x_reg, sat_y_reg;

    logic [DIST_W-1:0] rem_x2, rem_y2;
    logic              ge_x, ge_y;

    // Restoring step on both lanes.
    always_comb
    begin
        rem_x2 = {rem_x_reg[DIST_W-2:0], 1'b0};
        rem_y2 = {rem_y_reg[DIST_W-2:0], 1'b0};
        ge_x   = rem_x2 >= DIST_W'(div_x_reg);
        ge_y   = rem_y2 >= DIST_W'(div_y_reg);
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIST_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of both lanes.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_x_reg <= R_INIT;
            rem_y_reg <= R_INIT;
            quo_x_reg <= '0;
            quo_y_reg <= '0;
            div_x_reg <= req.mag_x;
            div_y_reg <= req.mag_y;
            sat_x_reg <= req.mag_x <= SAT_LIM;
            sat_y_reg <= req.mag_y <= SAT_LIM;
        end
        else if (busy_reg)
        begin
            rem_x_reg <= ge_x ? rem_x2 - DIST_W'(div_x_reg) : rem_x2;
            rem_y_reg <= ge_y ? rem_y2 - DIST_W'(div_y_reg) : rem_y2;
            quo_x_reg <= {quo_x_reg[DIST_W-2:0], ge_x};
            quo_y_reg <= {quo_y_reg[DIST_W-2:0], ge_y};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.step_x = sat_x_reg ? DIST_MAX : quo_x_reg;
    assign rsp.step_y = sat_y_reg ? DIST_MAX : quo_y_reg;

endmodule

// File: sv/grcd_front.sv
// ----------------------------------------------------------------------------
// grcd_front: item intake, direction and unit step setup
// Accepts items, turns a cast into direction magnitudes by an iterative
// rotator, gets the unit steps and the first side lengths, and queues a job.
// ----------------------------------------------------------------------------
module grcd_front
    import grcd_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    grcd_item_if.sink       item_ch,
    output grcd_recip_req_t recip_req,
    input  grcd_recip_rsp_t recip_rsp,
    output logic            push_valid,
    input  logic            push_ready,
    output grcd_job_t       push_data
);

    localparam logic [ANGLE_W-1:0] AMASK =
        (ANGLE_BITS >= ANGLE_W) ? {ANGLE_W{1'b1}} : ANGLE_W'((1 << ANGLE_BITS) - 1);
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int PROD_W = FRAC_BITS + DIST_W + 1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_ROT   = 7'b0000010,
        F_MAP   = 7'b0000100,
        F_START = 7'b0001000,
        F_DIV   = 7'b0010000,
        F_MULT  = 7'b0100000,
        F_PUSH  = 7'b1000000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic                  is_cast_reg;
    logic [CELL_IDX_W-1:0] row_reg, col_reg;
    logic                  wall_reg;
    logic [POS_W-1:0]      pos_x_reg, pos_y_reg;
    logic [1:0]            quad_reg;
    logic                  rem_zero_reg;
    logic signed [17:0]    rx_reg, ry_reg;
    logic signed [16:0]    rz_reg;
    logic [3:0]            iter_reg;
    logic [MAG_W-1:0]      mag_x_reg, mag_y_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic [DIST_W-1:0]     step_x_reg, step_y_reg;
    logic [PROD_W-1:0]     prod_x_reg, prod_y_reg;

    logic                  accept;
    logic [ANGLE_W-1:0]    angle_m;
    logic [15:0]           a16;
    logic signed [17:0]    xs, ys;
    logic signed [16:0]    atan_v;
    logic [MAG_W-1:0]      cos_m, sin_m;
    logic [FRAC_BITS:0]    dx, dy;

    assign accept        = item_ch.valid && item_ch.ready;
    assign item_ch.ready = (state_reg == F_IDLE);

    // Angle to a 16-bit turn code.
    assign angle_m = item_ch.angle & AMASK;
    assign a16     = 16'({4'b0, angle_m} << (16 - ANGLE_BITS));

    // One rotator stage.
    assign xs     = grcd_shr_tz(rx_reg, iter_reg);
    assign ys     = grcd_shr_tz(ry_reg, iter_reg);
    assign atan_v = 17'(grcd_atan(iter_reg));
    assign cos_m  = rem_zero_reg ? Q15_ONE : grcd_clamp_q15(rx_reg);
    assign sin_m  = rem_zero_reg ? '0      : grcd_clamp_q15(ry_reg);

    // Distance to the first cell boundary along each axis.
    assign dx = neg_x_reg ? {1'b0, pos_x_reg[FRAC_BITS-1:0]}
                          : ONE - {1'b0, pos_x_reg[FRAC_BITS-1:0]};
    assign dy = neg_y_reg ? {1'b0, pos_y_reg[FRAC_BITS-1:0]}
                          : ONE - {1'b0, pos_y_reg[FRAC_BITS-1:0]};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = (item_ch.op == OP_CAST) ? F_ROT : F_PUSH;
            F_ROT:
                if (iter_reg == 4'(CORDIC_STAGES - 1))
                    state_next = F_MAP;
            F_MAP:   state_next = F_START;
            F_START: state_next = F_DIV;
            F_DIV:
                if (recip_rsp.done)
                    state_next = F_MULT;
            F_MULT:  state_next = F_PUSH;
            F_PUSH:
                if (push_ready)
                    state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_cast_reg  <= item_ch.op == OP_CAST;
            row_reg      <= item_ch.cell_row;
            col_reg      <= item_ch.cell_col;
            wall_reg     <= item_ch.wall_bit;
            pos_x_reg    <= item_ch.pos_x;
            pos_y_reg    <= item_ch.pos_y;
            quad_reg     <= a16[15:14];
            rem_zero_reg <= a16[13:0] == 14'd0;
            rx_reg       <= CORDIC_GAIN;
            ry_reg       <= '0;
            rz_reg       <= 17'({3'b0, a16[13:0]});
            iter_reg     <= '0;
        end
        if (state_reg == F_ROT)
        begin
            if (!rz_reg[16])
            begin
                rx_reg <= rx_reg - ys;
                ry_reg <= ry_reg + xs;
                rz_reg <= rz_reg - atan_v;
            end
            else
            begin
                rx_reg <= rx_reg + ys;
                ry_reg <= ry_reg - xs;
                rz_reg <= rz_reg + atan_v;
            end
            iter_reg <= iter_reg + 4'd1;
        end
        // Fold the quadrant into magnitudes and signs; zero counts as positive.
        if (state_reg == F_MAP)
        begin
            unique case (quad_reg)
                QUAD_0:
                begin
                    mag_x_reg <= cos_m; neg_x_reg <= 1'b0;
                    mag_y_reg <= sin_m; neg_y_reg <= 1'b0;
                end
                QUAD_1:
                begin
                    mag_x_reg <= sin_m; neg_x_reg <= sin_m != '0;
                    mag_y_reg <= cos_m; neg_y_reg <= 1'b0;
                end
                QUAD_2:
                begin
                    mag_x_reg <= cos_m; neg_x_reg <= cos_m != '0;
                    mag_y_reg <= sin_m; neg_y_reg <= sin_m != '0;
                end
                QUAD_3:
                begin
                    mag_x_reg <= sin_m; neg_x_reg <= 1'b0;
                    mag_y_reg <= cos_m; neg_y_reg <= cos_m != '0;
                end
                default:
                begin
                    mag_x_reg <= cos_m; neg_x_reg <= 1'b0;
                    mag_y_reg <= sin_m; neg_y_reg <= 1'b0;
                end
            endcase
        end
        if (state_reg == F_DIV && recip_rsp.done)
        begin
            step_x_reg <= recip_rsp.step_x;
            step_y_reg <= recip_rsp.step_y;
        end
        if (state_reg == F_MULT)
        begin
            prod_x_reg <= PROD_W'(dx) * PROD_W'(step_x_reg);
            prod_y_reg <= PROD_W'(dy) * PROD_W'(step_y_reg);
        end
    end

    assign recip_req.start = (state_reg == F_START);
    assign recip_req.mag_x = mag_x_reg;
    assign recip_req.mag_y = mag_y_reg;

    // Job toward the walk.
    assign push_valid        = (state_reg == F_PUSH);
    assign push_data.is_cast = is_cast_reg;
    assign push_data.row     = row_reg;
    assign push_data.col     = col_reg;
    assign push_data.wall    = wall_reg;
    assign push_data.pos_x   = pos_x_reg;
    assign push_data.pos_y   = pos_y_reg;
    assign push_data.mag_x   = mag_x_reg;
    assign push_data.mag_y   = mag_y_reg;
    assign push_data.neg_x   = neg_x_reg;
    assign push_data.neg_y   = neg_y_reg;
    assign push_data.step_x  = step_x_reg;
    assign push_data.step_y  = step_y_reg;
    assign push_data.len_x   = grcd_sat_dist(18'(prod_x_reg >> FRAC_BITS));
    assign push_data.len_y   = grcd_sat_dist(18'(prod_y_reg >> FRAC_BITS));

    a_recip_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        recip_rsp.done |-> state_reg == F_DIV)
        else $error("reciprocal result arrived while the front was not waiting for it");

endmodule

// File: sv/grcd_queue.sv
// ----------------------------------------------------------------------------
// grcd_queue: short job queue between the front and the walk
// A small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
module grcd_queue
    import grcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  grcd_job_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output grcd_job_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    grcd_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == CNT_W'($past(count_reg) - CNT_W'(1)))
        else $error("queue count did not follow a pop");

endmodule

// File: sv/grcd_walk.sv
// ----------------------------------------------------------------------------
// grcd_walk: wall map and grid walk
// Owns the wall map memory, performs map writes, walks a cast one cell per
// cycle and computes the hit coordinate into the result register.
// ----------------------------------------------------------------------------
module grcd_walk
    import grcd_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  grcd_job_t     pop_data,
    grcd_result_if.source result_ch
);

    // Only cells with 5-bit indexes can ever be written; all others stay empty.
    localparam int MAP_W  = (GRID_WIDTH  < 32) ? GRID_WIDTH  : 32;
    localparam int MAP_H  = (GRID_HEIGHT < 32) ? GRID_HEIGHT : 32;
    localparam int CB     = $clog2(MAP_W);
    localparam int RB     = $clog2(MAP_H);
    localparam int AW     = CB + RB;
    localparam int DEPTH  = 1 << AW;
    localparam int IW     = POS_W - FRAC_BITS;
    localparam int GMAX   = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
    localparam int GW     = $clog2(GMAX + 2);
    localparam int CW     = ((IW > GW) ? IW : GW) + 2;
    localparam int LIMIT_I = ((GRID_WIDTH << FRAC_BITS) > 131071) ? 131071
                                                                 : (GRID_WIDTH << FRAC_BITS);
    localparam logic [DIST_W-1:0] LIMIT = DIST_W'(LIMIT_I);
    localparam int PROD_W = MAG_W + DIST_W;

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_WALK  = 5'b00100,
        B_MUL   = 5'b01000,
        B_DONE  = 5'b10000
    } walk_state_t;

    walk_state_t state_reg, state_next;

    logic                 mem [DEPTH];
    logic                 mem_q;
    logic [AW-1:0]        clr_addr_reg;

    logic signed [CW-1:0] cell_x_reg, cell_y_reg;
    logic [DIST_W-1:0]    len_x_reg, len_y_reg, step_x_reg, step_y_reg;
    logic [POS_W-1:0]     pos_x_reg, pos_y_reg;
    logic [MAG_W-1:0]     mag_x_reg, mag_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic                 vert_reg;
    logic                 in_grid_reg;
    logic                 last_valid_reg;
    logic                 hit_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [POS_W-1:0]     base_reg;
    logic                 neg_reg;

    logic                 out_valid_reg;
    logic                 out_hit_reg, out_vert_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic [HFRAC_W-1:0]   out_frac_reg;

    logic                 take_x;
    logic signed [CW-1:0] next_x, next_y;
    logic                 next_in_grid;
    logic [AW-1:0]        rd_addr;
    logic                 wall_now, stop;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 out_free;
    logic [FRAC_BITS-1:0] off_lo, coord_frac;

    function automatic logic cell_in_map(input logic signed [CW-1:0] cx,
                                         input logic signed [CW-1:0] cy);
        return !cx[CW-1] && (cx[CW-2:0] < (CW-1)'(MAP_W))
            && !cy[CW-1] && (cy[CW-2:0] < (CW-1)'(MAP_H));
    endfunction

    // One DDA step: advance along the axis whose crossing is nearer.
    assign take_x = len_x_reg < len_y_reg;
    always_comb
    begin
        next_x = cell_x_reg;
        next_y = cell_y_reg;
        if (take_x)
            next_x = neg_x_reg ? cell_x_reg - CW'(1) : cell_x_reg + CW'(1);
        else
            next_y = neg_y_reg ? cell_y_reg - CW'(1) : cell_y_reg + CW'(1);
    end
    assign next_in_grid = cell_in_map(next_x, next_y);
    assign rd_addr      = {next_y[RB-1:0], next_x[CB-1:0]};

    // The map word of the last step is back; decide whether the walk ends.
    assign wall_now = in_grid_reg && mem_q;
    assign stop     = last_valid_reg && (wall_now || dist_reg >= LIMIT);

    // Map writes from the queue; writes off the grid are dropped.
    assign pop_ready = (state_reg == B_IDLE);
    assign wr_addr   = {pop_data.row[RB-1:0], pop_data.col[CB-1:0]};
    assign wr_en     = pop_valid && pop_ready && !pop_data.is_cast
                    && ({1'b0, pop_data.row} < 6'(MAP_H))
                    && ({1'b0, pop_data.col} < 6'(MAP_W));

    // Hit coordinate fraction along the wall.
    assign off_lo     = prod_reg[15 + FRAC_BITS - 1:15];
    assign coord_frac = neg_reg ? base_reg[FRAC_BITS-1:0] - off_lo
                                : base_reg[FRAC_BITS-1:0] + off_lo;
    assign out_free   = !out_valid_reg || result_ch.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
                if (&clr_addr_reg)
                    state_next = B_IDLE;
            B_IDLE:
                if (pop_valid && pop_data.is_cast)
                    state_next = B_WALK;
            B_WALK:
                if (stop)
                    state_next = B_MUL;
            B_MUL:   state_next = B_DONE;
            B_DONE:
                if (out_free)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (state_reg == B_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Wall map: clearing pass, writes and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLEAR)
            mem[clr_addr_reg] <= 1'b0;
        else if (wr_en)
            mem[wr_addr] <= pop_data.wall;
        mem_q <= mem[rd_addr];
    end

    // Walk datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid && pop_data.is_cast)
        begin
            cell_x_reg     <= CW'(pop_data.pos_x >> FRAC_BITS);
            cell_y_reg     <= CW'(pop_data.pos_y >> FRAC_BITS);
            len_x_reg      <= pop_data.len_x;
            len_y_reg      <= pop_data.len_y;
            step_x_reg     <= pop_data.step_x;
            step_y_reg     <= pop_data.step_y;
            pos_x_reg      <= pop_data.pos_x;
            pos_y_reg      <= pop_data.pos_y;
            mag_x_reg      <= pop_data.mag_x;
            mag_y_reg      <= pop_data.mag_y;
            neg_x_reg      <= pop_data.neg_x;
            neg_y_reg      <= pop_data.neg_y;
            last_valid_reg <= 1'b0;
        end
        else if (state_reg == B_WALK)
        begin
            if (stop)
                hit_reg <= wall_now;
            else
            begin
                cell_x_reg     <= next_x;
                cell_y_reg     <= next_y;
                in_grid_reg    <= next_in_grid;
                last_valid_reg <= 1'b1;
                vert_reg       <= take_x;
                if (take_x)
                begin
                    dist_reg  <= len_x_reg;
                    len_x_reg <= grcd_sat_dist({1'b0, len_x_reg} + {1'b0, step_x_reg});
                end
                else
                begin
                    dist_reg  <= len_y_reg;
                    len_y_reg <= grcd_sat_dist({1'b0, len_y_reg} + {1'b0, step_y_reg});
                end
            end
        end
        // Offset along the wall: the other axis' magnitude times the distance.
        if (state_reg == B_MUL)
        begin
            prod_reg <= PROD_W'(vert_reg ? mag_y_reg : mag_x_reg) * PROD_W'(dist_reg);
            base_reg <= vert_reg ? pos_y_reg : pos_x_reg;
            neg_reg  <= vert_reg ? neg_y_reg : neg_x_reg;
        end
        if (state_reg == B_DONE && out_free)
        begin
            out_hit_reg  <= hit_reg;
            out_vert_reg <= vert_reg;
            out_dist_reg <= dist_reg;
            out_frac_reg <= HFRAC_W'({coord_frac, {HFRAC_W{1'b0}}} >> FRAC_BITS);
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.hit_found     = out_hit_reg;
    assign result_ch.vertical_side = out_vert_reg;
    assign result_ch.hit_distance  = out_dist_reg;
    assign result_ch.hit_fraction  = out_frac_reg;

    a_dist_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WALK && last_valid_reg) |=> dist_reg >= $past(dist_reg))
        else $error("walk distance went backward");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("result raised outside the finishing step");

endmodule

// File: sv/grid_ray_cast_dda.sv
// Order of work: a cast passes the rotator's 14 steps, the reciprocal's 17 steps and
// one multiply in the front, then the walk, one cell step per cycle, and the walk's
// offset multiply and result register; a map write skips the front's setup steps.
// The front can set up the next cast while the walk is still busy with the current
// one, as the job queue lies between them.
// Reset: asynchronous, active low; a clearing pass over every map entry follows.
// ----------------------------------------------------------------------------
// grid_ray_cast_dda: grid ray caster top level
// Joins the setup front, the job queue and the map walk.
// ----------------------------------------------------------------------------
module grid_ray_cast_dda
    import grcd_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int ANGLE_BITS  = DEF_ANGLE_BITS
)
(
    input logic           clk,
    input logic           rst_n,
    grcd_item_if.sink     item_ch,
    grcd_result_if.source result_ch
);

    grcd_recip_req_t recip_req;
    grcd_recip_rsp_t recip_rsp;
    logic            push_valid, push_ready;
    grcd_job_t       push_data;
    logic            pop_valid, pop_ready;
    grcd_job_t       pop_data;

    grcd_recip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (recip_req),
        .rsp   (recip_rsp)
    );

    grcd_front #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .recip_req  (recip_req),
        .recip_rsp  (recip_rsp),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    grcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    grcd_walk #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .FRAC_BITS   (FRAC_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result_ch (result_ch)
    );

endmodule

// File: bench/grid_ray_cast_dda_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_cast_dda_tb: self-checking bench of the grid ray caster
// Drives map writes and ray casts through the item channel, predicts each
// cast's result with its own DDA walk over a local copy of the wall map, and
// compares results in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module grid_ray_cast_dda_tb;
    import grcd_pkg::*;

    typedef struct packed {
        logic        op;
        logic [4:0]  cell_row;
        logic [4:0]  cell_col;
        logic        wall_bit;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] angle;
    } ray_item_t;

    typedef struct packed {
        logic        hit_found;
        logic        vertical_side;
        logic [16:0] hit_distance;
        logic [10:0] hit_fraction;
    } ray_hit_t;

    localparam int GW = 32;
    localparam int GH = 32;
    localparam int FB = 11;
    localparam int AB = 12;
    localparam longint SAT = 131071;

    logic clk;
    logic rst_n;
    grcd_item_if   item_ch ();
    grcd_result_if result_ch ();

    grid_ray_cast_dda i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch.sink),
        .result_ch (result_ch.source)
    );

    ray_item_t pending_items[$];
    ray_hit_t  expected_hits[$];
    bit        shadow_map[GW*GH];
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_phase = 0;
    bit        stimulus_done = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rotator magnitudes for a remainder within one quadrant.
    task automatic rotate_quadrant(input int rem, output longint c, output longint s);
        int atan_tab[14];
        int x, y, z, xs, ys;
        atan_tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        if (rem == 0)
        begin
            c = 32768;
            s = 0;
        end
        else
        begin
            x = 19899;
            y = 0;
            z = rem;
            for (int i = 0; i < 14; i++)
            begin
                xs = (x < 0) ? -((-x) >>> i) : (x >>> i);
                ys = (y < 0) ? -((-y) >>> i) : (y >>> i);
                if (z >= 0)
                begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
                else
                begin
                    x += ys; y -= xs; z += atan_tab[i];
                end
            end
            c = (x < 0) ? 0 : (x > 32768 ? 32768 : x);
            s = (y < 0) ? 0 : (y > 32768 ? 32768 : y);
        end
    endtask

    function automatic longint clip_distance(input longint v);
        return (v > SAT) ? SAT : v;
    endfunction

    function automatic longint axis_step(input longint m);
        return (m <= 0) ? SAT : clip_distance((64'd1 << (15 + FB)) / m);
    endfunction

    // Applies a write to the shadow map, or walks a cast and queues its result.
    task automatic predict_item(input ray_item_t it);
        longint one, fmask, c, s, mx, my, ux, uy, lenx, leny, walk_dist, lim;
        longint base, mag, off, coord, px, py;
        int quad, a16, cellx, celly;
        bit negx, negy, hit, vert, neg;
        ray_hit_t r;
        one = 64'd1 << FB;
        fmask = one - 1;
        if (it.op == OP_WRITE)
        begin
            if (it.cell_row < GH && it.cell_col < GW)
                shadow_map[it.cell_row * GW + it.cell_col] = it.wall_bit;
        end
        else
        begin
            px = it.pos_x;
            py = it.pos_y;
            a16 = ((it.angle & ((1 << AB) - 1)) << (16 - AB)) & 16'hFFFF;
            quad = a16 >> 14;
            rotate_quadrant(a16 & 16'h3FFF, c, s);
            case (quad)
                0: begin mx = c; negx = 0;      my = s; negy = 0;      end
                1: begin mx = s; negx = s != 0; my = c; negy = 0;      end
                2: begin mx = c; negx = c != 0; my = s; negy = s != 0; end
                default: begin mx = s; negx = 0; my = c; negy = c != 0; end
            endcase
            ux = axis_step(mx);
            uy = axis_step(my);
            cellx = int'(px >> FB);
            celly = int'(py >> FB);
            lenx = clip_distance(((negx ? (px & fmask) : one - (px & fmask)) * ux) >> FB);
            leny = clip_distance(((negy ? (py & fmask) : one - (py & fmask)) * uy) >> FB);
            lim = clip_distance(GW * one);
            walk_dist = 0;
            hit = 0;
            vert = 0;
            while (!hit && walk_dist < lim)
            begin
                if (lenx < leny)
                begin
                    cellx += negx ? -1 : 1;
                    walk_dist = lenx;
                    lenx = clip_distance(lenx + ux);
                    vert = 1;
                end
                else
                begin
                    celly += negy ? -1 : 1;
                    walk_dist = leny;
                    leny = clip_distance(leny + uy);
                    vert = 0;
                end
                hit = (cellx >= 0 && cellx < GW && celly >= 0 && celly < GH)
                      ? shadow_map[celly * GW + cellx] : 1'b0;
            end
            if (vert)
            begin
                base = py; mag = my; neg = negy;
            end
            else
            begin
                base = px; mag = mx; neg = negx;
            end
            off = (mag * walk_dist) >> 15;
            coord = neg ? base - off : base + off;
            r.hit_found = hit;
            r.vertical_side = vert;
            r.hit_distance = walk_dist[16:0];
            r.hit_fraction = coord[10:0];
            expected_hits.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic ray_item_t make_write(input int row, input int col, input bit wall);
        ray_item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.cell_row = 5'(row);
        it.cell_col = 5'(col);
        it.wall_bit = wall;
        it.pos_x = 16'($urandom);
        it.pos_y = 16'($urandom);
        it.angle = 12'($urandom);
        return it;
    endfunction

    function automatic ray_item_t make_cast(input int x, input int y, input int ang);
        ray_item_t it;
        it = '0;
        it.op = OP_CAST;
        it.cell_row = 5'($urandom);
        it.cell_col = 5'($urandom);
        it.wall_bit = 1'($urandom);
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.angle = 12'(ang);
        return it;
    endfunction

    // Sender: bursts of items with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            {item_ch.op, item_ch.cell_row, item_ch.cell_col, item_ch.wall_bit,
             item_ch.pos_x, item_ch.pos_y, item_ch.angle} <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_item(pending_items.pop_front());
                burst_left = burst_left - 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (burst_left <= 0 && gap_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end
                if (gap_left > 0 && burst_left > 0 && !item_ch.valid)
                begin
                    gap_left = gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0 && burst_left > 0)
                begin
                    item_ch.valid <= 1'b1;
                    {item_ch.op, item_ch.cell_row, item_ch.cell_col, item_ch.wall_bit,
                     item_ch.pos_x, item_ch.pos_y, item_ch.angle} <= pending_items[0];
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                    if (burst_left <= 0)
                        gap_left = $urandom_range(0, 40);
                end
            end
        end
    end

    // Receiver: stalls on a rotating pattern, with stall-free stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    ray_hit_t e;
                    e = expected_hits.pop_front();
                    if (result_ch.hit_found !== e.hit_found)
                        report_mismatch($sformatf("hit_found %b exp %b",
                                        result_ch.hit_found, e.hit_found));
                    if (result_ch.vertical_side !== e.vertical_side)
                        report_mismatch($sformatf("vertical_side %b exp %b",
                                        result_ch.vertical_side, e.vertical_side));
                    if (result_ch.hit_distance !== e.hit_distance)
                        report_mismatch($sformatf("hit_distance %0d exp %0d",
                                        result_ch.hit_distance, e.hit_distance));
                    if (result_ch.hit_fraction !== e.hit_fraction)
                        report_mismatch($sformatf("hit_fraction %0d exp %0d",
                                        result_ch.hit_fraction, e.hit_fraction));
                end
            end
            stall_phase = (stall_phase + 1) % 512;
            if (stall_phase < 160)
                result_ch.ready <= 1'b1;
            else if (stall_phase < 320)
                result_ch.ready <= (stall_phase % 7) < 3;
            else
                result_ch.ready <= $urandom_range(0, 2) != 0 && (stall_phase % 53) > 8;
        end
    end

    // Stimulus: directed items, then random map writes and casts.
    initial
    begin
        int angs[8];
        angs = '{0, 1024, 2048, 3072, 4095, 512, 1, 2047};
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Open map, axis-aligned and extreme casts, then corner walls and walls round the centre.
        pending_items.push_back(make_cast(16'h8400, 16'h8400, 0));
        pending_items.push_back(make_cast(16'h0000, 16'h0000, 2048));
        pending_items.push_back(make_cast(16'hFFFF, 16'hFFFF, 4095));
        pending_items.push_back(make_write(0, 0, 1));
        pending_items.push_back(make_write(31, 31, 1));
        pending_items.push_back(make_write(16, 20, 1));
        pending_items.push_back(make_write(20, 16, 1));
        pending_items.push_back(make_write(16, 12, 1));
        pending_items.push_back(make_write(12, 16, 1));
        foreach (angs[i])
            pending_items.push_back(make_cast(16'h8000 + 16'h0200, 16'h8000 + 16'h0555,
                                              angs[i]));
        pending_items.push_back(make_cast(16'h8000, 16'h8000, 1536));
        pending_items.push_back(make_write(16, 20, 0));
        pending_items.push_back(make_cast(16'h8000, 16'h8000, 0));
        pending_items.push_back(make_cast(16'h0400, 16'h0400, 2560));

        // Random part: mostly casts into a map that fills and empties over time.
        for (int n = 0; n < 1050; n++)
        begin
            if ($urandom_range(0, 9) < 4)
                pending_items.push_back(make_write($urandom, $urandom,
                                                   $urandom_range(0, 3) != 0));
            else if ($urandom_range(0, 9) == 0)
                pending_items.push_back(make_cast($urandom, $urandom,
                                                  angs[$urandom_range(0, 7)]));
            else
                pending_items.push_back(make_cast($urandom, $urandom, $urandom));
        end

        wait (pending_items.size() == 0);
        wait (expected_hits.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a hung block.
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
